### hdl/signed_int_to_decimal_ascii_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for signed_int_to_decimal_ascii
// Concurrent assertion wrappers that are empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH

`ifndef SYNTHESIS
`define SIDA_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("signed_int_to_decimal_ascii: assertion failed");
`define SIDA_ASSERT_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("signed_int_to_decimal_ascii: forbidden condition seen");
`else
`define SIDA_ASSERT(label, clk, rstn, prop)
`define SIDA_ASSERT_NEVER(label, clk, rstn, cond)
`endif

`endif

### hdl/sida_pkg.sv
// ----------------------------------------------------------------------------
// sida_pkg
// Widths, character codes and the binary to BCD step for the converter.
// ----------------------------------------------------------------------------
package sida_pkg;

    localparam int VALUE_W        = 32;
    localparam int CHAR_W         = 6;
    localparam int DIGIT_W        = 4;
    localparam int NUM_DIGITS     = 10;
    localparam int BCD_W          = NUM_DIGITS * DIGIT_W;
    localparam int IDX_W          = $clog2(NUM_DIGITS);
    localparam int BITS_PER_STAGE = 4;
    localparam int NUM_CONV       = VALUE_W / BITS_PER_STAGE;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [BCD_W-1:0]   bcd_t;
    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [CHAR_W-1:0]  char_t;

    // One double-dabble step: correct every digit of five or more, then shift in a bit.
    function automatic bcd_t dabble_step(bcd_t bcd, logic b);
        bcd_t adj;
        adj = bcd;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
                adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W] + 4'd3;
            end
        end
        return {adj[BCD_W-2:0], b};
    endfunction

endpackage

### hdl/signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed 32-bit integer to its decimal ASCII text, one character
// per output item, most significant first, with the last character flagged.
//
//   Channel   Dir   tdata                     tuser   tlast
//   s_        in    [31:0] value              -       -
//   m_        out   [5:0] char_code, pad 0    -       is_last
//
// An input item enters a load stage and eight conversion stages that each
// retire four bits of the magnitude, then passes to the serializer and the
// output register. The serializer sends one character per cycle while m_ is
// not stalled, so an item gives one to eleven characters, set by its sign and
// digit count. Reset clears all valid bits. A stall on m_ holds the
// output register and backs up the pipeline without loss or repetition.
// ----------------------------------------------------------------------------
`include "signed_int_to_decimal_ascii_assert.svh"

module signed_int_to_decimal_ascii (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sida_pkg::VALUE_W-1:0]  s_tdata,   // [31:0] value
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // [5:0] char_code, [7:6] zero
    output logic                          m_tlast    // is_last
);
    import sida_pkg::*;

    localparam int LAST = NUM_CONV;

    logic   v_reg   [LAST+1];
    logic   neg_reg [LAST+1];
    bcd_t   bcd_reg [LAST+1];
    value_t bin_reg [LAST+1];
    logic   stage_ready [LAST+2];

    logic                ser_busy_reg;
    logic                ser_sign_reg;
    idx_t                ser_idx_reg;
    logic [DIGIT_W-1:0]  ser_digit_reg [NUM_DIGITS];
    logic                m_tvalid_reg;
    char_t               m_char_reg;
    logic                m_last_reg;

    logic  out_free;
    logic  ser_ready;
    logic  ser_load;
    idx_t  lead_idx;
    bcd_t  conv_next [LAST+1];
    char_t char_next;
    logic  last_next;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign ser_ready = !ser_busy_reg || (out_free && !ser_sign_reg && ser_idx_reg == '0);
    assign ser_load  = v_reg[LAST] && ser_ready;

    always_comb begin
        stage_ready[LAST+1] = ser_ready;
        for (int k = LAST; k >= 0; k--) begin
            stage_ready[k] = !v_reg[k] || stage_ready[k+1];
        end
    end

    assign s_tready = stage_ready[0];

    always_comb begin
        conv_next[0] = '0;
        for (int k = 1; k <= LAST; k++) begin
            conv_next[k] = bcd_reg[k-1];
            for (int j = 0; j < BITS_PER_STAGE; j++) begin
                conv_next[k] = dabble_step(conv_next[k], bin_reg[k-1][VALUE_W-1-j]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= LAST; k++) begin
                v_reg[k] <= 1'b0;
            end
        end else begin
            if (stage_ready[0]) begin
                v_reg[0]   <= s_tvalid;
                neg_reg[0] <= s_tdata[VALUE_W-1];
                bin_reg[0] <= s_tdata[VALUE_W-1] ? (~s_tdata + value_t'(1)) : s_tdata;
                bcd_reg[0] <= conv_next[0];
            end
            for (int k = 1; k <= LAST; k++) begin
                if (stage_ready[k]) begin
                    v_reg[k]   <= v_reg[k-1];
                    neg_reg[k] <= neg_reg[k-1];
                    bin_reg[k] <= {bin_reg[k-1][VALUE_W-BITS_PER_STAGE-1:0],
                                   {BITS_PER_STAGE{1'b0}}};
                    bcd_reg[k] <= conv_next[k];
                end
            end
        end
    end

    always_comb begin
        lead_idx = '0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd_reg[LAST][i*DIGIT_W +: DIGIT_W] != '0) begin
                lead_idx = idx_t'(i);
            end
        end
    end

    always_comb begin
        if (ser_sign_reg) begin
            char_next = ASCII_MINUS;
            last_next = 1'b0;
        end else begin
            char_next = ASCII_ZERO + char_t'(ser_digit_reg[ser_idx_reg]);
            last_next = (ser_idx_reg == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ser_busy_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (out_free) begin
                m_tvalid_reg <= ser_busy_reg;
                m_char_reg   <= char_next;
                m_last_reg   <= last_next;
            end
            if (ser_load) begin
                ser_busy_reg <= 1'b1;
                ser_sign_reg <= neg_reg[LAST];
                ser_idx_reg  <= lead_idx;
                for (int i = 0; i < NUM_DIGITS; i++) begin
                    ser_digit_reg[i] <= bcd_reg[LAST][i*DIGIT_W +: DIGIT_W];
                end
            end else if (ser_busy_reg && out_free) begin
                if (ser_sign_reg) begin
                    ser_sign_reg <= 1'b0;
                end else if (ser_idx_reg == '0) begin
                    ser_busy_reg <= 1'b0;
                end else begin
                    ser_idx_reg <= ser_idx_reg - idx_t'(1);
                end
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(8-CHAR_W){1'b0}}, m_char_reg};
    assign m_tlast  = m_last_reg;

    `SIDA_ASSERT(a_minus_never_last, aclk, aresetn,
        (m_tvalid_reg && m_char_reg == ASCII_MINUS) |-> !m_last_reg)
    `SIDA_ASSERT_NEVER(a_idx_in_range, aclk, aresetn,
        ser_busy_reg && ser_idx_reg > idx_t'(NUM_DIGITS-1))
    `SIDA_ASSERT(a_tail_holds, aclk, aresetn,
        (v_reg[LAST] && !ser_ready) |=> (v_reg[LAST] && $stable(bcd_reg[LAST])))
    `SIDA_ASSERT(a_load_needs_room, aclk, aresetn,
        (ser_load && ser_busy_reg) |-> (out_free && !ser_sign_reg))

endmodule
